/* rtl/imm_pkg.sv */
// Shared constants, types and helpers for the int8 matmul requantize core.
// Used by imm_requant, the top level and the checker; depends on nothing.
package imm_pkg;

  localparam int NUM_CHANNELS = 2;
  localparam int REDUCE_LEN   = 768;

  localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int WT_DEPTH  = NUM_CHANNELS * REDUCE_LEN;
  localparam int WA_W      = (WT_DEPTH > 1) ? $clog2(WT_DEPTH) : 1;

  localparam int CHAN_W    = 4;
  localparam int POS_W     = 10;
  localparam int DATA_W    = 8;
  localparam int SCALE_W   = 32;
  localparam int ACC_W     = 26;
  localparam int MAG_W     = 25;
  localparam int FRAC_BITS = 24;
  localparam int SPLIT_W   = 16;
  localparam int PART_W    = MAG_W + SPLIT_W;
  localparam int PROD_W    = MAG_W + SCALE_W;
  localparam int Q_W       = PROD_W - FRAC_BITS + 1;

  localparam logic [1:0] MODE_WEIGHT = 2'd0;
  localparam logic [1:0] MODE_SCALE  = 2'd1;
  localparam logic [1:0] MODE_ACT    = 2'd2;

  localparam logic [DATA_W-1:0] INT8_MAX = 8'h7f;
  localparam logic [DATA_W-1:0] INT8_MIN = 8'h80;

  typedef struct packed {
    logic                    valid;
    logic signed [ACC_W-1:0] acc;
    logic [SCALE_W-1:0]      scale;
    logic [CHAN_W-1:0]       chan;
    logic                    last;
  } rq_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
    logic [CHAN_W-1:0] chan;
    logic              sat;
    logic              last;
  } rq_res_t;

  function automatic logic [WA_W-1:0] wt_addr(input logic [CHAN_W-1:0] ch,
                                              input logic [POS_W-1:0] pos);
    logic [CHAN_W+POS_W:0] a;
    a = (CHAN_W+POS_W+1)'(ch) * (CHAN_W+POS_W+1)'(REDUCE_LEN)
        + (CHAN_W+POS_W+1)'(pos);
    return a[WA_W-1:0];
  endfunction

endpackage

/* rtl/imm_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; no package dependency.
module imm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/imm_requant.sv */
// Multi-cycle requantize unit: |acc| times Q8.24 scale in two 16-bit halves,
// round to nearest even, saturate to int8. Depends on imm_pkg.
module imm_requant
  import imm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  rq_req_t req_i,
  output rq_res_t res_o
);

  localparam logic [FRAC_BITS-1:0] HALF = {1'b1, {(FRAC_BITS-1){1'b0}}};

  logic [4:0]            v_q, v_d;
  logic                  neg_q;
  logic [MAG_W-1:0]      mag_q;
  logic [SCALE_W-1:0]    scale_q;
  logic [CHAN_W-1:0]     chan_q;
  logic                  last_q;
  logic [PART_W-1:0]     plo_q, phi_q;
  logic [PROD_W-1:0]     prod_q;
  logic [DATA_W-1:0]     res_q;
  logic                  sat_q;

  logic [ACC_W-1:0]      acc_u;
  logic [ACC_W-1:0]      abs_w;
  logic [Q_W-2:0]        q_w;
  logic [FRAC_BITS-1:0]  rem_w;
  logic                  up_w;
  logic [Q_W-1:0]        qr_w;
  logic                  sat_w;
  logic [DATA_W-1:0]     res_w;

  assign v_d   = {v_q[3:0], req_i.valid};
  assign acc_u = req_i.acc;
  assign abs_w = acc_u[ACC_W-1] ? (~acc_u + 1'b1) : acc_u;

  always_comb begin
    q_w   = prod_q[PROD_W-1:FRAC_BITS];
    rem_w = prod_q[FRAC_BITS-1:0];
    up_w  = (rem_w > HALF) || ((rem_w == HALF) && q_w[0]);
    qr_w  = Q_W'(q_w) + Q_W'(up_w);
    if (neg_q) begin
      sat_w = qr_w > Q_W'(128);
      res_w = sat_w ? INT8_MIN : (~qr_w[DATA_W-1:0] + 1'b1);
    end else begin
      sat_w = qr_w > Q_W'(127);
      res_w = sat_w ? INT8_MAX : qr_w[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      neg_q   <= acc_u[ACC_W-1];
      mag_q   <= abs_w[MAG_W-1:0];
      scale_q <= req_i.scale;
      chan_q  <= req_i.chan;
      last_q  <= req_i.last;
    end
    if (v_q[0]) begin
      plo_q <= PART_W'(mag_q) * PART_W'(scale_q[SPLIT_W-1:0]);
    end
    if (v_q[1]) begin
      phi_q <= PART_W'(mag_q) * PART_W'(scale_q[SCALE_W-1:SPLIT_W]);
    end
    if (v_q[2]) begin
      prod_q <= {phi_q, {SPLIT_W{1'b0}}} + PROD_W'(plo_q);
    end
    if (v_q[3]) begin
      res_q <= res_w;
      sat_q <= sat_w;
    end
  end

  assign res_o.done   = v_q[4];
  assign res_o.result = res_q;
  assign res_o.chan   = chan_q;
  assign res_o.sat    = sat_q;
  assign res_o.last   = last_q;

endmodule

/* rtl/int8_matmul_requant_core.sv */
// Top level of the int8 matrix multiply core with per-channel requantize.
// Depends on imm_pkg, imm_ram and imm_requant.
//
// Words on the input stream load weights (mode 0) and Q8.24 scales (mode 1), or
// carry one activation byte (mode 2). An activation is accepted in the idle state,
// which issues the first reads, then takes one multiply-accumulate per channel on
// the single shared MAC, which reads the weight RAM and the accumulator RAM and
// writes the accumulator back. After the last activation of a row each channel
// goes through the requantize unit in turn (accumulator read, four-stage split
// multiply and round, hand-off to the output register), waiting while the output
// side stalls; no input word is taken during that phase. The accumulators start
// from zero through per-channel valid bits, so no clearing pass follows reset.
module int8_matmul_requant_core
  import imm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // channel[3:0], position[13:4], weight_value[21:14], scale_value[53:22],
  // activation[61:54], zero[63:62]
  input  logic [63:0] s_axis_tdata_i,
  // mode[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // result[7:0], out_channel[11:8], saturated[12], zero[15:13]
  output logic [15:0] m_axis_tdata_o,
  // row_last
  output logic        m_axis_tlast_o
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_MAC     = 3'd1;
  localparam logic [2:0] ST_RQ_RD   = 3'd2;
  localparam logic [2:0] ST_RQ_GO   = 3'd3;
  localparam logic [2:0] ST_RQ_WAIT = 3'd4;
  localparam logic [2:0] ST_RQ_PUT  = 3'd5;

  logic [2:0]              state_q, state_d;
  logic [CH_W-1:0]         n_q, n_d;
  logic [POS_W-1:0]        p_q, p_d;
  logic [NUM_CHANNELS-1:0] acc_vld_q, acc_vld_d;
  logic signed [DATA_W-1:0] act_q;
  logic [SCALE_W-1:0]      scale_q [NUM_CHANNELS];
  logic                    out_vld_q, out_vld_d;
  logic [DATA_W-1:0]       out_res_q;
  logic [CHAN_W-1:0]       out_ch_q;
  logic                    out_sat_q;
  logic                    out_last_q;

  logic [1:0]              in_mode;
  logic [CHAN_W-1:0]       in_chan;
  logic [POS_W-1:0]        in_pos;
  logic [DATA_W-1:0]       in_wt;
  logic [SCALE_W-1:0]      in_scale;
  logic [DATA_W-1:0]       in_act;
  logic                    in_take;
  logic                    ch_ok, pos_ok;
  logic                    wt_we, scale_we, act_load, out_load;

  logic [CH_W-1:0]         n_nxt;
  logic                    n_last, row_end;
  logic [WA_W-1:0]         wt_raddr, wt_waddr;
  logic [DATA_W-1:0]       wt_rdata;
  logic [CH_W-1:0]         acc_raddr;
  logic [ACC_W-1:0]        acc_rdata;
  logic signed [ACC_W-1:0] acc_cur, acc_sum;
  logic signed [2*DATA_W-1:0] mac_prod;

  rq_req_t rq_req;
  rq_res_t rq_res;

  assign in_mode  = s_axis_tuser_i;
  assign in_chan  = s_axis_tdata_i[3:0];
  assign in_pos   = s_axis_tdata_i[13:4];
  assign in_wt    = s_axis_tdata_i[21:14];
  assign in_scale = s_axis_tdata_i[53:22];
  assign in_act   = s_axis_tdata_i[61:54];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_take  = s_axis_tvalid_i && s_axis_tready_o;
  assign ch_ok    = {1'b0, in_chan} < (CHAN_W+1)'(NUM_CHANNELS);
  assign pos_ok   = {1'b0, in_pos} < (POS_W+1)'(REDUCE_LEN);
  assign wt_we    = in_take && (in_mode == MODE_WEIGHT) && ch_ok && pos_ok;
  assign scale_we = in_take && (in_mode == MODE_SCALE) && ch_ok;
  assign act_load = in_take && (in_mode == MODE_ACT);
  assign wt_waddr = wt_addr(in_chan, in_pos);

  assign n_nxt   = n_q + 1'b1;
  assign n_last  = (n_q == CH_W'(NUM_CHANNELS - 1));
  assign row_end = (p_q == POS_W'(REDUCE_LEN - 1));

  assign wt_raddr  = (state_q == ST_IDLE) ? wt_addr('0, p_q) : wt_addr(CHAN_W'(n_nxt), p_q);
  assign acc_raddr = (state_q == ST_IDLE) ? '0 : ((state_q == ST_MAC) ? n_nxt : n_q);

  assign acc_cur  = acc_vld_q[n_q] ? $signed(acc_rdata) : '0;
  assign mac_prod = act_q * $signed(wt_rdata);
  assign acc_sum  = acc_cur + ACC_W'(mac_prod);

  imm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (WT_DEPTH)
  ) u_wt_ram (
    .clk_i   (clk_i),
    .we_i    (wt_we),
    .waddr_i (wt_waddr),
    .wdata_i (in_wt),
    .raddr_i (wt_raddr),
    .rdata_o (wt_rdata)
  );

  imm_ram #(
    .WIDTH (ACC_W),
    .DEPTH (NUM_CHANNELS)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_MAC),
    .waddr_i (n_q),
    .wdata_i (acc_sum),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  assign rq_req.valid = (state_q == ST_RQ_GO);
  assign rq_req.acc   = acc_cur;
  assign rq_req.scale = scale_q[n_q];
  assign rq_req.chan  = CHAN_W'(n_q);
  assign rq_req.last  = n_last;

  imm_requant u_requant (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rq_req),
    .res_o  (rq_res)
  );

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    p_d       = p_q;
    acc_vld_d = acc_vld_q;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (act_load) begin
          n_d     = '0;
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        acc_vld_d[n_q] = 1'b1;
        if (n_last) begin
          n_d = '0;
          if (row_end) begin
            p_d     = '0;
            state_d = ST_RQ_RD;
          end else begin
            p_d     = p_q + 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          n_d = n_nxt;
        end
      end
      ST_RQ_RD: begin
        state_d = ST_RQ_GO;
      end
      ST_RQ_GO: begin
        state_d = ST_RQ_WAIT;
      end
      ST_RQ_WAIT: begin
        if (rq_res.done) begin
          state_d = ST_RQ_PUT;
        end
      end
      ST_RQ_PUT: begin
        if (!out_vld_q || m_axis_tready_i) begin
          out_load       = 1'b1;
          acc_vld_d[n_q] = 1'b0;
          if (n_last) begin
            n_d     = '0;
            state_d = ST_IDLE;
          end else begin
            n_d     = n_nxt;
            state_d = ST_RQ_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      n_q       <= '0;
      p_q       <= '0;
      acc_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      n_q       <= n_d;
      p_q       <= p_d;
      acc_vld_q <= acc_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (act_load) begin
      act_q <= $signed(in_act);
    end
    if (scale_we) begin
      scale_q[in_chan[CH_W-1:0]] <= in_scale;
    end
    if (out_load) begin
      out_res_q  <= rq_res.result;
      out_ch_q   <= rq_res.chan;
      out_sat_q  <= rq_res.sat;
      out_last_q <= rq_res.last;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {3'b000, out_sat_q, out_ch_q, out_res_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

/* rtl/imm_checker.sv */
// Port-level checks for the int8 matmul requantize core, bound to the top level.
// Depends on imm_pkg and int8_matmul_requant_core.
module imm_checker
  import imm_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [63:0] s_axis_tdata_i,
  input logic [1:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output word changed while stalled");

  // last flag only on the highest channel
  a_last_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (m_axis_tlast_o == (m_axis_tdata_o[11:8] == CHAN_W'(NUM_CHANNELS - 1))))
    else $error("row_last does not match channel");

  // saturation flag implies a clamped value
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[12] |->
      (m_axis_tdata_o[7:0] == INT8_MAX) || (m_axis_tdata_o[7:0] == INT8_MIN))
    else $error("saturated word with unclamped value");

  // no input word taken in the middle of a row's results
  a_no_input_mid_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> !s_axis_tready_o)
    else $error("input ready during row results");

endmodule

bind int8_matmul_requant_core imm_checker u_imm_checker (.*);
